@@ rtl/core/masu_pkg.sv @@
// Shared types, constants and lookup functions for the motif affinity scanner.
package masu_pkg;

    localparam int MAX_MOTIF_DEF  = 32;
    localparam int COUNT_BITS_DEF = 24;
    localparam int SCORE_W        = 40;
    localparam int WIN_CNT_W      = 24;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_BASE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [1:0] CFG_MOTIF_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LN_R0        = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LT = 8'h74;

    localparam logic [3:0] EXP_LAST_BIT = 4'd11;
    localparam logic [5:0] SIG_DIV_STEPS = 6'd17;
    localparam logic [5:0] FIN_DIV_STEPS = 6'd41;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         symbol;
        logic [4:0]         position;
        logic [1:0]         weight_base;
        logic signed [15:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0]   score;
        logic [WIN_CNT_W-1:0] valid_windows;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_DRAIN,
        S_SIG_INIT,
        S_EXP_MUL,
        S_EXP_RND,
        S_SIG_DIVLD,
        S_SIG_DIV,
        S_SIG_DONE,
        S_COMB_MUL,
        S_COMB_ACC,
        S_END,
        S_FIN_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_clear;
        logic sum_step;
        logic sig_init;
        logic exp_mul;
        logic exp_round;
        logic sig_div_load;
        logic fin_div_load;
        logic div_step;
        logic sig_done;
        logic comb_mul;
        logic comb_acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic window_ok;
        logic m_last;
        logic x_sat;
        logic k_last;
        logic div_done;
        logic sig_sel_c;
        logic cnt_zero;
        logic count_mode;
        logic out_free;
    } status_t;

    // valid flag in bit 2, base code in bits 1:0
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] r;
        case (ch)
            CH_UA, CH_LA: r = 3'b100;
            CH_UC, CH_LC: r = 3'b101;
            CH_UG, CH_LG: r = 3'b110;
            CH_UT, CH_LT: r = 3'b111;
            default:      r = 3'b000;
        endcase
        return r;
    endfunction

    // exp(-2^k/256) in Q0.32
    function automatic logic [31:0] exp_factor(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd0:    r = 32'd4278222805;
            4'd1:    r = 32'd4261543595;
            4'd2:    r = 32'd4228380000;
            4'd3:    r = 32'd4162825044;
            4'd4:    r = 32'd4034748382;
            4'd5:    r = 32'd3790295335;
            4'd6:    r = 32'd3344923893;
            4'd7:    r = 32'd2605029347;
            4'd8:    r = 32'd1580030169;
            4'd9:    r = 32'd581260615;
            4'd10:   r = 32'd78665070;
            4'd11:   r = 32'd1440801;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/masu_datapath.sv @@
// Datapath: weight memory, base window, energy sums, sigmoid, divider, accumulators.
module masu_datapath #(
    parameter int MAX_MOTIF  = masu_pkg::MAX_MOTIF_DEF,
    parameter int COUNT_BITS = masu_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  masu_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  masu_pkg::cmd_t      cmd,
    output masu_pkg::status_t   status,
    input  logic                out_ready,
    output logic                out_valid,
    output masu_pkg::out_item_t out_data
);

    localparam int MW    = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;
    localparam int LW    = $clog2(MAX_MOTIF + 1);
    localparam int AW    = MW + 2;
    localparam int DEPTH = 4 * MAX_MOTIF;
    localparam int EW    = 17 + MW;
    localparam int VW    = (COUNT_BITS > masu_pkg::WIN_CNT_W) ? COUNT_BITS : masu_pkg::WIN_CNT_W;
    localparam logic signed [EW:0] X_HI = 4096;
    localparam logic signed [EW:0] X_LO = -4096;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // configuration
    logic [5:0]         ml_reg;
    logic signed [15:0] ln_r0_reg;
    logic               oc_reg;

    // weight memory
    logic signed [15:0] wmem [DEPTH];
    logic signed [15:0] rd_f_reg;
    logic signed [15:0] rd_c_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      af;
    logic [AW-1:0]      ac;

    // window and sums
    logic [2:0]          win_reg [MAX_MOTIF];
    logic [LW-1:0]       fill_reg;
    logic [LW-1:0]       len;
    logic [MW-1:0]       lenm1;
    logic [MW-1:0]       m_reg;
    logic [MW-1:0]       j;
    logic [1:0]          b;
    logic                pend_reg;
    logic signed [EW-1:0] ef_reg;
    logic signed [EW-1:0] ec_reg;
    logic                sel_reg;
    logic                win_ok;
    logic                base_acc;

    // sigmoid
    logic signed [EW:0] x;
    logic [EW:0]        x_abs;
    logic               x_hi;
    logic               x_lo;
    logic [11:0]        a_reg;
    logic               neg_reg;
    logic               sat_reg;
    logic               sat_hi_reg;
    logic               e_one_reg;
    logic [31:0]        e_reg;
    logic [3:0]         k_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        prod_rnd;
    logic [32:0]        e_full;
    logic [33:0]        dsig;
    logic [48:0]        nsig;
    logic [48:0]        nfin;
    logic [15:0]        p_val;
    logic [15:0]        pf_reg;
    logic [15:0]        pc_reg;

    // divider
    logic [34:0]        rem_reg;
    logic [48:0]        num_reg;
    logic [33:0]        d_reg;
    logic [48:0]        q_reg;
    logic [5:0]         dcnt_reg;
    logic [34:0]        r2;
    logic               ge;

    // combine and accumulate
    logic [32:0]             cprod_reg;
    logic [16:0]             comb;
    logic [40:0]             sum41;
    logic [39:0]             sum_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [VW-1:0]           cnt_ext;
    logic [masu_pkg::WIN_CNT_W-1:0] vw;

    logic                out_valid_reg;
    masu_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ml_reg    <= 6'd1;
            ln_r0_reg <= '0;
            oc_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                masu_pkg::CFG_MOTIF_LENGTH: ml_reg <= cfg_data[5:0];
                masu_pkg::CFG_LN_R0:        ln_r0_reg <= cfg_data;
                masu_pkg::CFG_OUTPUT_COUNT: oc_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        if (ml_reg == 6'd0)
            len = LW'(1);
        else if (7'(ml_reg) > 7'(MAX_MOTIF))
            len = LW'(MAX_MOTIF);
        else
            len = LW'(ml_reg);
        lenm1 = MW'(len - LW'(1));
        j     = lenm1 - m_reg;
        b     = win_reg[j][1:0];
        af    = {m_reg, b};
        ac    = {j, ~b};
        wr_en = cmd.accept && (in_data.kind == masu_pkg::KIND_LOAD)
                && (7'(in_data.position) < 7'(MAX_MOTIF));
        wr_addr  = AW'({in_data.position, in_data.weight_base});
        base_acc = cmd.accept && (in_data.kind == masu_pkg::KIND_BASE);
        win_ok   = (fill_reg >= len);
        for (int i = 0; i < MAX_MOTIF; i++)
        begin
            if ((LW'(i) < len) && !win_reg[i][2])
                win_ok = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[wr_addr] <= in_data.weight;
        rd_f_reg <= wmem[af];
        rd_c_reg <= wmem[ac];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_MOTIF; i++)
                win_reg[i] <= 3'b000;
            fill_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            for (int i = 0; i < MAX_MOTIF; i++)
                win_reg[i] <= 3'b000;
            fill_reg <= '0;
        end
        else if (base_acc)
        begin
            for (int i = MAX_MOTIF - 1; i > 0; i--)
                win_reg[i] <= win_reg[i-1];
            win_reg[0] <= masu_pkg::base_code(in_data.symbol);
            if (fill_reg < LW'(MAX_MOTIF))
                fill_reg <= fill_reg + LW'(1);
        end
    end

    always_comb
    begin
        x     = (EW+1)'(ln_r0_reg) - (EW+1)'(sel_reg ? ec_reg : ef_reg);
        x_hi  = (x >= X_HI);
        x_lo  = (x <= X_LO);
        x_abs = (x < 0) ? (EW+1)'(-x) : (EW+1)'(x);
        prod_rnd = prod_reg + 64'h0000_0000_8000_0000;
        e_full = e_one_reg ? 33'h1_0000_0000 : {1'b0, e_reg};
        dsig   = 34'h1_0000_0000 + 34'(e_full);
        nsig   = (neg_reg ? (49'(e_full) << 16) : 49'h1_0000_0000_0000) + 49'(dsig >> 1);
        nfin   = 49'(sum_reg) + 49'(cnt_reg >> 1);
        r2     = {rem_reg[33:0], num_reg[48]};
        ge     = (r2 >= {1'b0, d_reg});
        if (sat_reg)
            p_val = sat_hi_reg ? 16'hFFFF : 16'h0000;
        else if (q_reg > 49'd65535)
            p_val = 16'hFFFF;
        else
            p_val = q_reg[15:0];
        comb  = 17'(pf_reg) + 17'((cprod_reg + 33'd32768) >> 16);
        sum41 = 41'(sum_reg) + 41'(comb);
        cnt_ext = VW'(cnt_reg);
        if (cnt_ext > VW'({masu_pkg::WIN_CNT_W{1'b1}}))
            vw = '1;
        else
            vw = cnt_ext[masu_pkg::WIN_CNT_W-1:0];
    end

    // energy sums and sigmoid work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            sel_reg  <= 1'b0;
            m_reg    <= '0;
            k_reg    <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            pend_reg <= cmd.sum_step;
            if (cmd.sum_clear)
            begin
                m_reg   <= '0;
                sel_reg <= 1'b0;
            end
            else if (cmd.sum_step)
                m_reg <= m_reg + MW'(1);
            if (cmd.sig_done)
                sel_reg <= ~sel_reg;
            if (cmd.sig_init)
                k_reg <= '0;
            else if (cmd.exp_round)
                k_reg <= k_reg + 4'd1;
            if (cmd.sig_div_load)
                dcnt_reg <= masu_pkg::SIG_DIV_STEPS;
            else if (cmd.fin_div_load)
                dcnt_reg <= masu_pkg::FIN_DIV_STEPS;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
        begin
            ef_reg <= '0;
            ec_reg <= '0;
        end
        else if (pend_reg)
        begin
            ef_reg <= ef_reg + EW'(rd_f_reg);
            ec_reg <= ec_reg + EW'(rd_c_reg);
        end
        if (cmd.sig_init)
        begin
            a_reg      <= x_abs[11:0];
            neg_reg    <= (x < 0);
            sat_reg    <= x_hi || x_lo;
            sat_hi_reg <= x_hi;
            e_one_reg  <= 1'b1;
        end
        if (cmd.exp_mul)
            prod_reg <= 64'(e_reg) * 64'(masu_pkg::exp_factor(k_reg));
        if (cmd.exp_round && a_reg[k_reg])
        begin
            e_reg     <= e_one_reg ? masu_pkg::exp_factor(k_reg) : prod_rnd[63:32];
            e_one_reg <= 1'b0;
        end
        if (cmd.sig_div_load)
        begin
            rem_reg <= 35'(nsig[48:17]);
            num_reg <= {nsig[16:0], 32'd0};
            d_reg   <= dsig;
            q_reg   <= '0;
        end
        else if (cmd.fin_div_load)
        begin
            rem_reg <= '0;
            num_reg <= nfin << 8;
            d_reg   <= 34'(cnt_reg);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? (r2 - {1'b0, d_reg}) : r2;
            num_reg <= num_reg << 1;
            q_reg   <= {q_reg[47:0], ge};
        end
        if (cmd.sig_done)
        begin
            if (sel_reg)
                pc_reg <= p_val;
            else
                pf_reg <= p_val;
        end
        if (cmd.comb_mul)
            cprod_reg <= 33'(17'h10000 - 17'(pf_reg)) * 33'(pc_reg);
    end

    // sequence accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                sum_reg       <= '0;
                cnt_reg       <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (cmd.comb_acc)
                begin
                    sum_reg <= sum41[40] ? 40'hFF_FFFF_FFFF : sum41[39:0];
                    if (cnt_reg != CNT_MAX)
                        cnt_reg <= cnt_reg + COUNT_BITS'(1);
                end
                if (out_ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cnt_reg == '0)
                out_data_reg.score <= '0;
            else if (oc_reg)
                out_data_reg.score <= sum_reg;
            else
                out_data_reg.score <= q_reg[39:0];
            out_data_reg.valid_windows <= vw;
        end
    end

    always_comb
    begin
        status.window_ok  = win_ok;
        status.m_last     = (m_reg == lenm1);
        status.x_sat      = x_hi || x_lo;
        status.k_last     = (k_reg == masu_pkg::EXP_LAST_BIT);
        status.div_done   = (dcnt_reg == 6'd0);
        status.sig_sel_c  = sel_reg;
        status.cnt_zero   = (cnt_reg == '0);
        status.count_mode = oc_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(MAX_MOTIF))
        else $error("fill count beyond window depth");

    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.out_load |=> cnt_reg >= $past(cnt_reg))
        else $error("window count dropped without a clear");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an untaken beat");

    a_sig_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sig_done && !sat_reg) |-> (q_reg <= 49'd65536))
        else $error("sigmoid quotient out of range");

endmodule

@@ rtl/core/masu_ctrl.sv @@
// Controller state machine: sequences window scoring, sigmoid steps and end-of-sequence output.
module masu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_kind,
    output logic               in_ready,
    input  masu_pkg::status_t  status,
    output masu_pkg::cmd_t     cmd
);

    masu_pkg::state_t state_reg;
    masu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= masu_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            masu_pkg::S_IDLE:
            begin
                if (in_valid && (in_kind == masu_pkg::KIND_BASE))
                    state_next = masu_pkg::S_CHECK;
                else if (in_valid && (in_kind == masu_pkg::KIND_END))
                    state_next = masu_pkg::S_END;
            end
            masu_pkg::S_CHECK:
                state_next = status.window_ok ? masu_pkg::S_SUM : masu_pkg::S_IDLE;
            masu_pkg::S_SUM:
                if (status.m_last)
                    state_next = masu_pkg::S_DRAIN;
            masu_pkg::S_DRAIN:
                state_next = masu_pkg::S_SIG_INIT;
            masu_pkg::S_SIG_INIT:
                state_next = status.x_sat ? masu_pkg::S_SIG_DONE : masu_pkg::S_EXP_MUL;
            masu_pkg::S_EXP_MUL:
                state_next = masu_pkg::S_EXP_RND;
            masu_pkg::S_EXP_RND:
                state_next = status.k_last ? masu_pkg::S_SIG_DIVLD : masu_pkg::S_EXP_MUL;
            masu_pkg::S_SIG_DIVLD:
                state_next = masu_pkg::S_SIG_DIV;
            masu_pkg::S_SIG_DIV:
                if (status.div_done)
                    state_next = masu_pkg::S_SIG_DONE;
            masu_pkg::S_SIG_DONE:
                state_next = status.sig_sel_c ? masu_pkg::S_COMB_MUL : masu_pkg::S_SIG_INIT;
            masu_pkg::S_COMB_MUL:
                state_next = masu_pkg::S_COMB_ACC;
            masu_pkg::S_COMB_ACC:
                state_next = masu_pkg::S_IDLE;
            masu_pkg::S_END:
                if (status.cnt_zero || status.count_mode)
                    state_next = masu_pkg::S_OUT;
                else
                    state_next = masu_pkg::S_FIN_DIV;
            masu_pkg::S_FIN_DIV:
                if (status.div_done)
                    state_next = masu_pkg::S_OUT;
            masu_pkg::S_OUT:
                if (status.out_free)
                    state_next = masu_pkg::S_IDLE;
            default:
                state_next = masu_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            masu_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            masu_pkg::S_CHECK:     cmd.sum_clear = 1'b1;
            masu_pkg::S_SUM:       cmd.sum_step = 1'b1;
            masu_pkg::S_SIG_INIT:  cmd.sig_init = 1'b1;
            masu_pkg::S_EXP_MUL:   cmd.exp_mul = 1'b1;
            masu_pkg::S_EXP_RND:   cmd.exp_round = 1'b1;
            masu_pkg::S_SIG_DIVLD: cmd.sig_div_load = 1'b1;
            masu_pkg::S_SIG_DIV:   cmd.div_step = !status.div_done;
            masu_pkg::S_SIG_DONE:  cmd.sig_done = 1'b1;
            masu_pkg::S_COMB_MUL:  cmd.comb_mul = 1'b1;
            masu_pkg::S_COMB_ACC:  cmd.comb_acc = 1'b1;
            masu_pkg::S_END:
                cmd.fin_div_load = !(status.cnt_zero || status.count_mode);
            masu_pkg::S_FIN_DIV:   cmd.div_step = !status.div_done;
            masu_pkg::S_OUT:       cmd.out_load = status.out_free;
            default:               cmd = '0;
        endcase
    end

    a_one_div_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sig_div_load && cmd.fin_div_load))
        else $error("two divider loads at once");

    a_accept_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (in_kind == masu_pkg::KIND_BASE)) |=> state_reg == masu_pkg::S_CHECK)
        else $error("base beat did not start a window check");

    a_ready_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == masu_pkg::S_IDLE))
        else $error("input ready outside idle");

endmodule

@@ rtl/core/motif_affinity_scanner_unit.sv @@
// Top level of the motif affinity scanner: controller plus datapath.
//
//  channel | signals                              | role
//  in      | in_valid, in_ready, in_data          | load weight / base / end beats
//  out     | out_valid, out_ready, out_data       | one result per end beat
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register writes, always ready
//
// A base beat with a scored window runs L serial weight reads over the two-port
// weight memory, then per strand 12 multiply/round pairs and a divider pass
// (17 steps); a saturated sigmoid skips the pairs and the divider for its strand.
// An end beat runs the 41-step divider for the mean unless the count is zero or
// totals are chosen. Reset clears window, counters and out_valid and restores the
// configuration, not the weight memory or work registers. The output register
// frees the core; it stalls only when a new result meets a held one.
module motif_affinity_scanner_unit #(
    parameter int MAX_MOTIF  = masu_pkg::MAX_MOTIF_DEF,
    parameter int COUNT_BITS = masu_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  masu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output masu_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    masu_pkg::cmd_t    cmd;
    masu_pkg::status_t status;

    assign cfg_ready = 1'b1;

    masu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    masu_datapath #(
        .MAX_MOTIF  (MAX_MOTIF),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ tb/sv/tb_motif_affinity_scanner_unit.sv @@
// Self-checking testbench for the motif affinity scanner top level.
module tb_motif_affinity_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXM = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [39:0] SUM_SAT = 40'hFF_FFFF_FFFF;
    localparam logic [23:0] CNT_SAT = 24'hFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    masu_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready = 1'b0;
    masu_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;

    motif_affinity_scanner_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scanner state mirror
    logic signed [15:0] energy_w [0:4*MAXM-1];
    logic [2:0]         win [0:MAXM-1];
    int unsigned        fill;
    logic [39:0]        occ_sum;
    logic [23:0]        win_cnt;
    logic [5:0]         cur_len;
    logic signed [15:0] cur_r0;
    logic               cur_total;

    masu_pkg::out_item_t score_q [$];
    int        errors = 0;
    int        dir_errors;
    int        idle_cycles = 0;

    logic [63:0] exp_tab [0:11];

    initial
    begin
        exp_tab[0] = 64'd4278222805; exp_tab[1] = 64'd4261543595;
        exp_tab[2] = 64'd4228380000; exp_tab[3] = 64'd4162825044;
        exp_tab[4] = 64'd4034748382; exp_tab[5] = 64'd3790295335;
        exp_tab[6] = 64'd3344923893; exp_tab[7] = 64'd2605029347;
        exp_tab[8] = 64'd1580030169; exp_tab[9] = 64'd581260615;
        exp_tab[10] = 64'd78665070;  exp_tab[11] = 64'd1440801;
    end

    function automatic logic [2:0] decode_base(input logic [7:0] ch);
        case (ch)
            masu_pkg::CH_UA, masu_pkg::CH_LA: return 3'b100;
            masu_pkg::CH_UC, masu_pkg::CH_LC: return 3'b101;
            masu_pkg::CH_UG, masu_pkg::CH_LG: return 3'b110;
            masu_pkg::CH_UT, masu_pkg::CH_LT: return 3'b111;
            default:                          return 3'b000;
        endcase
    endfunction

    function automatic logic [63:0] bound_prob(input int x);
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] p;
        int unsigned a;
        if (x >= 4096)
            return 64'd65535;
        if (x <= -4096)
            return 64'd0;
        a = (x < 0) ? -x : x;
        e = 64'd1 << 32;
        for (int k = 0; k < 12; k++)
            if (a[k])
                e = (e * exp_tab[k] + (64'd1 << 31)) >> 32;
        d = (64'd1 << 32) + e;
        if (x >= 0)
            p = ((64'd1 << 48) + (d >> 1)) / d;
        else
            p = ((e << 16) + (d >> 1)) / d;
        return (p > 64'd65535) ? 64'd65535 : p;
    endfunction

    function automatic void clear_seq();
        for (int i = 0; i < MAXM; i++)
            win[i] = 3'b000;
        fill = 0;
        occ_sum = '0;
        win_cnt = '0;
    endfunction

    function automatic void score_window();
        int unsigned len;
        int ef;
        int ec;
        int unsigned b;
        logic [63:0] pf;
        logic [63:0] pc;
        logic [63:0] comb;
        logic [63:0] s;
        len = cur_len;
        if (len < 1) len = 1;
        if (len > MAXM) len = MAXM;
        if (fill < len)
            return;
        for (int m = 0; m < len; m++)
            if (!win[len-1-m][2])
                return;
        ef = 0;
        ec = 0;
        for (int m = 0; m < len; m++)
        begin
            b = win[len-1-m][1:0];
            ef += energy_w[m*4 + b];
            ec += energy_w[(len-1-m)*4 + (3-b)];
        end
        pf = bound_prob(int'(cur_r0) - ef);
        pc = bound_prob(int'(cur_r0) - ec);
        comb = pf + (((64'd65536 - pf) * pc + 64'd32768) >> 16);
        s = {24'd0, occ_sum} + comb;
        occ_sum = (s > {24'd0, SUM_SAT}) ? SUM_SAT : s[39:0];
        if (win_cnt != CNT_SAT)
            win_cnt++;
    endfunction

    // returns 1 when the beat produces a result
    function automatic bit predict_item(input masu_pkg::in_item_t it,
                                        output masu_pkg::out_item_t r);
        logic [63:0] q;
        r = '0;
        case (it.kind)
            masu_pkg::KIND_LOAD:
            begin
                energy_w[it.position*4 + it.weight_base] = it.weight;
                return 0;
            end
            masu_pkg::KIND_BASE:
            begin
                for (int i = MAXM-1; i > 0; i--)
                    win[i] = win[i-1];
                win[0] = decode_base(it.symbol);
                if (fill < MAXM) fill++;
                score_window();
                return 0;
            end
            masu_pkg::KIND_END:
            begin
                q = 0;
                if (win_cnt != 0)
                begin
                    if (cur_total)
                        q = occ_sum;
                    else
                        q = ({24'd0, occ_sum} + (win_cnt >> 1)) / win_cnt;
                end
                r.score = q[39:0];
                r.valid_windows = win_cnt;
                clear_seq();
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    always #5 clk = ~clk;

    // receiver with its own stall pattern
    int stall_mode = 1;
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (score_q.size() == 0)
            begin
                $display("%0t: unexpected result score=%h windows=%h", $time,
                         out_data.score, out_data.valid_windows);
                errors++;
            end
            else
            begin
                masu_pkg::out_item_t ex;
                ex = score_q.pop_front();
                if (ex.score !== out_data.score)
                begin
                    $display("%0t: score expected %h actual %h", $time,
                             ex.score, out_data.score);
                    errors++;
                end
                if (ex.valid_windows !== out_data.valid_windows)
                begin
                    $display("%0t: valid_windows expected %h actual %h", $time,
                             ex.valid_windows, out_data.valid_windows);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    int burst_left;

    // present one beat and return at the edge that takes it
    task automatic drive_item(input masu_pkg::in_item_t it);
        // random gap between bursts
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk iff in_ready);
    endtask

    task automatic send_item(input masu_pkg::in_item_t it);
        masu_pkg::out_item_t r;
        drive_item(it);
        if (predict_item(it, r))
            score_q.push_back(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk iff cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            masu_pkg::CFG_MOTIF_LENGTH: cur_len = val[5:0];
            masu_pkg::CFG_LN_R0:        cur_r0 = val;
            masu_pkg::CFG_OUTPUT_COUNT: cur_total = val[0];
            default: ;
        endcase
    endtask

    function automatic masu_pkg::in_item_t mk(input logic [1:0] k, input logic [7:0] s,
                                              input logic [4:0] p, input logic [1:0] b,
                                              input logic [15:0] w);
        masu_pkg::in_item_t it;
        it.kind = k; it.symbol = s; it.position = p; it.weight_base = b; it.weight = w;
        return it;
    endfunction

    function automatic logic [7:0] rand_symbol();
        logic [7:0] acgt [0:7];
        acgt = '{masu_pkg::CH_UA, masu_pkg::CH_UC, masu_pkg::CH_UG, masu_pkg::CH_UT,
                 masu_pkg::CH_LA, masu_pkg::CH_LC, masu_pkg::CH_LG, masu_pkg::CH_LT};
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom);
        return acgt[$urandom_range(0, 7)];
    endfunction

    typedef struct {
        masu_pkg::in_item_t  it;
        bit                  known;
        masu_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t            dir_rows [$];
    dir_row_t            row;
    masu_pkg::out_item_t got;
    int                  sent;

    initial
    begin
        rst_n = 0;
        in_valid = 0; in_data = '0;
        cfg_valid = 0; cfg_index = masu_pkg::CFG_MOTIF_LENGTH; cfg_data = '0;
        dir_errors = 0; burst_left = 0;
        for (int i = 0; i < 4*MAXM; i++) energy_w[i] = '0;
        clear_seq();
        cur_len = 1; cur_r0 = 0; cur_total = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table so no unwritten entry is read
        for (int p = 0; p < MAXM; p++)
            for (int b = 0; b < 4; b++)
                send_item(mk(masu_pkg::KIND_LOAD, 0, p, b,
                             16'($urandom_range(0, 1023)) - 16'sd512));

        // directed table
        dir_rows.push_back('{mk(masu_pkg::KIND_END, 0, 0, 0, 0), 1, '{40'd0, 24'd0}});
        dir_rows.push_back('{mk(masu_pkg::KIND_LOAD, 0, 0, 0, 16'h7FFF), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_LOAD, 0, 0, 3, 16'h8000), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_LOAD, 0, 31, 1, 16'h0000), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, masu_pkg::CH_UA, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, masu_pkg::CH_LT, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, masu_pkg::CH_UC, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, masu_pkg::CH_LG, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, 8'hFF, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, 8'h00, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(2'd3, 8'hFF, 5'h1F, 3, 16'hFFFF), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_END, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_BASE, 8'h55, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(masu_pkg::KIND_END, 0, 0, 0, 0), 1, '{40'd0, 24'd0}});
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.known)
            begin
                if (!(predict_item(row.it, got) && got == row.want))
                begin
                    $display("%0t: directed row %0d table %h model %h", $time, i,
                             row.want, got);
                    dir_errors++;
                end
                score_q.push_back(row.want);
                drive_item(row.it);
            end
            else
                send_item(row.it);
        end
        drain();

        // random phases over register settings, extremes included
        sent = 0;
        for (int ph = 0; sent < 1250; ph++)
        begin
            logic [5:0] len;
            logic [15:0] r0;
            int seqs;
            case (ph % 6)
                0: len = 6'd1;
                1: len = 6'd32;
                2: len = 6'd0;
                3: len = 6'd63;
                default: len = 6'($urandom_range(1, 8));
            endcase
            case (ph % 4)
                0: r0 = 16'h7FFF;
                1: r0 = 16'h8000;
                default: r0 = 16'($urandom_range(0, 4095)) - 16'sd2048;
            endcase
            write_reg(masu_pkg::CFG_MOTIF_LENGTH, {10'd0, len});
            write_reg(masu_pkg::CFG_LN_R0, r0);
            write_reg(masu_pkg::CFG_OUTPUT_COUNT, 16'(ph % 2));
            seqs = $urandom_range(2, 5);
            for (int s = 0; s < seqs; s++)
            begin
                int n;
                n = $urandom_range(0, 12);
                for (int j = 0; j < n; j++)
                begin
                    int pick;
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        send_item(mk(masu_pkg::KIND_LOAD, 8'($urandom), 5'($urandom),
                                     2'($urandom), 16'($urandom)));
                    else if (pick == 1)
                        send_item(mk(2'd3, 8'($urandom), 5'($urandom),
                                     2'($urandom), 16'($urandom)));
                    else
                        send_item(mk(masu_pkg::KIND_BASE, rand_symbol(), 5'($urandom),
                                     2'($urandom), 16'($urandom)));
                    sent++;
                end
                send_item(mk(masu_pkg::KIND_END, 8'($urandom), 5'($urandom),
                             2'($urandom), 16'($urandom)));
                sent++;
            end
            drain();
        end

        drain();
        if (errors == 0 && dir_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ motif_affinity_scanner_unit.f @@
rtl/core/masu_pkg.sv
rtl/core/masu_datapath.sv
rtl/core/masu_ctrl.sv
rtl/core/motif_affinity_scanner_unit.sv
tb/sv/tb_motif_affinity_scanner_unit.sv
